/* rtl/core/assert_macros.svh */
// Assertion macros shared by the allocator RTL.
// Define NO_ASSERTIONS to compile them out.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
`define ASSERT_AT(lbl, clk, rst_n, prop) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
		else $error("assertion failed");
`define ASSERT_NEVER_AT(lbl, clk, rst_n, prop) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) !(prop)) \
		else $error("forbidden condition seen");
`else
`define ASSERT_AT(lbl, clk, rst_n, prop)
`define ASSERT_NEVER_AT(lbl, clk, rst_n, prop)
`endif
`endif

/* rtl/core/p2sa_pkg.sv */
// Types and codes of the power-of-two split block allocator.
// No dependencies.
package p2sa_pkg;
	localparam int OP_W = 2;
	localparam int REQ_W = 21;
	localparam int USER_W = 20;
	localparam int CFG_W = 5;
	localparam int TAG_W = 5;
	localparam int CLS_W = 6;
	localparam int SZ_W = REQ_W + 1;
	localparam int ST_W = 3;
	localparam logic [CLS_W-1:0] MIN_CHUNK_LOG2 = 6'd5;
	localparam logic [CFG_W-1:0] CHUNK_LOG2_RST = 5'd16;

	typedef enum logic [OP_W-1:0] {
		OP_ALLOC  = 2'd0,
		OP_FREE   = 2'd1,
		OP_RESIZE = 2'd2
	} op_t;

	typedef enum logic [ST_W-1:0] {
		ST_OK      = 3'd0,
		ST_IGNORED = 3'd1,
		ST_NO_POOL = 3'd2,
		ST_TOO_BIG = 3'd3,
		ST_GROW    = 3'd4
	} status_t;

	typedef struct packed {
		logic [OP_W-1:0]   operation;
		logic [REQ_W-1:0]  request_bytes;
		logic [USER_W-1:0] user_address;
	} in_item_t;

	typedef struct packed {
		logic [USER_W-1:0] result_address;
		logic [ST_W-1:0]   status;
	} out_item_t;

	typedef struct packed {
		logic we_link;
		logic we_tag;
	} mem_ctl_t;
endpackage

/* rtl/core/p2sa_store.sv */
// Link and class tag memories, one shared address, registered read.
// Depends on p2sa_pkg.
module p2sa_store import p2sa_pkg::*; #(
	parameter int ADDR_BITS = 20,
	parameter int SLOT_BITS = 16
) (
	input  logic                 clk,
	input  logic [SLOT_BITS-1:0] addr,
	input  mem_ctl_t             ctl,
	input  logic [ADDR_BITS:0]   link_wdata,
	input  logic [TAG_W-1:0]     tag_wdata,
	output logic [ADDR_BITS:0]   link_rdata,
	output logic [TAG_W-1:0]     tag_rdata
);
	logic [ADDR_BITS:0] link_mem [2**SLOT_BITS];
	logic [TAG_W-1:0]   tag_mem  [2**SLOT_BITS];

	always_ff @(posedge clk) begin
		if (ctl.we_link) begin
			link_mem[addr] <= link_wdata;
		end
		link_rdata <= link_mem[addr];
	end

	always_ff @(posedge clk) begin
		if (ctl.we_tag) begin
			tag_mem[addr] <= tag_wdata;
		end
		tag_rdata <= tag_mem[addr];
	end
endmodule

/* rtl/core/p2sa_class_search.sv */
// Iterative size class search: smallest c with 2^c >= size, one compare a cycle.
// Depends on p2sa_pkg.
module p2sa_class_search import p2sa_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [SZ_W-1:0]  size,
	output logic             done,
	output logic [CLS_W-1:0] cls
);
	logic             busy_q;
	logic [CLS_W-1:0] c_q;
	logic [SZ_W-1:0]  size_q;
	logic             below;

	assign below = ((SZ_W+1)'(1) << c_q) < {1'b0, size_q};
	assign done  = busy_q && !below;
	assign cls   = c_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			c_q    <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			c_q    <= '0;
			size_q <= size;
		end else if (busy_q) begin
			if (below) begin
				c_q <= c_q + 1'b1;
			end else begin
				busy_q <= 1'b0;
			end
		end
	end
endmodule

/* rtl/core/pow2_split_block_allocator.sv */
// Power-of-two split block allocator, top level with request sequencer.
// Depends on p2sa_pkg, p2sa_store, p2sa_class_search, assert_macros.svh.
//
// One request at a time; in_ready is high only while idle. Every request ends
// in S_FINISH, which loads the output register once no result still waits
// there. A free of a real block adds the memory states S_FREE_RD and S_FREE_DEC.
// An allocate or resize adds the size class search, which steps through the
// classes up to the rounded size, then S_ALLOC_DEC for an allocate or S_RSZ_RD
// and S_RSZ_DEC for a resize. A pop from a list adds S_POP_RD and S_POP_WR. A
// fresh chunk split or a shrink adds S_HALVES, one memory write per buddy half
// pushed; that is up to chunk_log2 (or the old class on a shrink) minus the
// class. The shared link/tag memory port and the class comparator set this
// sequence. A null free and the unused code go straight to S_FINISH. A result
// waits in an output register. The next request is taken in S_IDLE and runs
// until its result is ready to load. Memories need no clearing pass after reset.
`include "assert_macros.svh"
module pow2_split_block_allocator import p2sa_pkg::*; #(
	parameter int ADDR_BITS = 20,
	parameter int HEADER_BYTES = 16
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	input  in_item_t         in_item,
	output logic             out_valid,
	input  logic             out_ready,
	output out_item_t        out_item,
	input  logic             cfg_we,
	input  logic [CFG_W-1:0] cfg_data
);
	localparam int MC = $clog2(HEADER_BYTES);
	localparam int SLOT_W = ADDR_BITS - MC;
	localparam int NUM_CLS = ADDR_BITS + 1;
	localparam int HIDX_W = $clog2(NUM_CLS);
	localparam logic [CLS_W-1:0] A_CLS = CLS_W'(ADDR_BITS);

	typedef enum logic [3:0] {
		S_IDLE, S_CLS_WAIT, S_ALLOC_DEC, S_POP_RD, S_POP_WR, S_FREE_RD,
		S_FREE_DEC, S_RSZ_RD, S_RSZ_DEC, S_HALVES, S_FINISH
	} state_t;

	state_t               state_q;
	logic                 rsz_q;
	logic [ADDR_BITS-1:0] blk_q;
	logic [ADDR_BITS-1:0] user_q;
	logic [CLS_W-1:0]     cls_q;
	logic [CLS_W-1:0]     k_q;
	logic [CLS_W-1:0]     hi_q;
	logic [ADDR_BITS:0]   cp_q;
	logic [ADDR_BITS-1:0] res_q;
	status_t              st_q;
	logic                 out_valid_q;
	out_item_t            out_item_q;
	logic [CFG_W-1:0]     chunk_q;
	logic                 head_ok_q   [NUM_CLS];
	logic [ADDR_BITS-1:0] head_addr_q [NUM_CLS];

	logic                 accept;
	logic [ADDR_BITS-1:0] user_ext;
	logic [CLS_W-1:0]     ch;
	logic [ADDR_BITS+1:0] csize;
	logic                 exhausted;
	logic [ADDR_BITS-1:0] half_a;
	logic                 halves_go;
	logic [CLS_W-1:0]     cap;
	logic                 free_ign;
	logic [HIDX_W-1:0]    cls_idx;
	logic [HIDX_W-1:0]    lk_idx;
	logic                 srch_start;
	logic                 srch_done;
	logic [CLS_W-1:0]     srch_cls;
	logic [SLOT_W-1:0]    mem_addr;
	mem_ctl_t             mem_ctl;
	logic [ADDR_BITS:0]   link_wdata;
	logic [TAG_W-1:0]     tag_wdata;
	logic [ADDR_BITS:0]   link_rdata;
	logic [TAG_W-1:0]     tag_rdata;

	assign in_ready  = (state_q == S_IDLE);
	assign accept    = in_valid && in_ready;
	assign out_valid = out_valid_q;
	assign out_item  = out_item_q;
	assign user_ext  = ADDR_BITS'(in_item.user_address);

	assign ch = (CLS_W'(chunk_q) < MIN_CHUNK_LOG2) ? MIN_CHUNK_LOG2 :
		(CLS_W'(chunk_q) > A_CLS) ? A_CLS : CLS_W'(chunk_q);
	assign csize     = (ADDR_BITS+2)'(1) << ch;
	assign exhausted = ({1'b0, cp_q} + csize) > ((ADDR_BITS+2)'(1) << ADDR_BITS);
	assign half_a    = blk_q + (ADDR_BITS'(1) << k_q);
	assign halves_go = (k_q < hi_q) && (k_q < A_CLS);
	assign cap       = CLS_W'(tag_rdata);
	assign cls_idx   = cls_q[HIDX_W-1:0];
	assign free_ign  = (cap >= CLS_W'(NUM_CLS)) ||
		(head_ok_q[cap[HIDX_W-1:0]] && head_addr_q[cap[HIDX_W-1:0]] == blk_q);
	assign lk_idx    = (state_q == S_FREE_DEC) ? cap[HIDX_W-1:0] : k_q[HIDX_W-1:0];

	assign srch_start = accept && ((in_item.operation == OP_ALLOC) ||
		(in_item.operation == OP_RESIZE));

	always_comb begin
		mem_ctl    = '0;
		tag_wdata  = TAG_W'(cls_q);
		link_wdata = {head_ok_q[lk_idx], head_addr_q[lk_idx]};
		mem_addr   = blk_q[ADDR_BITS-1:MC];
		case (state_q)
			S_ALLOC_DEC: begin
				mem_addr = cp_q[ADDR_BITS-1:MC];
				mem_ctl.we_tag = (cls_q <= ch) && !head_ok_q[cls_idx] && !exhausted;
			end
			S_POP_WR: mem_ctl.we_tag = 1'b1;
			S_FREE_DEC: mem_ctl.we_link = !free_ign;
			S_RSZ_DEC: mem_ctl.we_tag = (cls_q <= cap);
			S_HALVES: begin
				mem_addr = half_a[ADDR_BITS-1:MC];
				tag_wdata = TAG_W'(k_q);
				mem_ctl.we_tag = halves_go;
				mem_ctl.we_link = halves_go;
			end
			default: ;
		endcase
	end

	p2sa_store #(
		.ADDR_BITS(ADDR_BITS),
		.SLOT_BITS(SLOT_W)
	) u_store (
		.clk(clk),
		.addr(mem_addr),
		.ctl(mem_ctl),
		.link_wdata(link_wdata),
		.tag_wdata(tag_wdata),
		.link_rdata(link_rdata),
		.tag_rdata(tag_rdata)
	);

	p2sa_class_search u_search (
		.clk(clk),
		.arst_n(arst_n),
		.start(srch_start),
		.size(SZ_W'(in_item.request_bytes) + SZ_W'(HEADER_BYTES)),
		.done(srch_done),
		.cls(srch_cls)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
			cp_q        <= '0;
			chunk_q     <= CHUNK_LOG2_RST;
			for (int i = 0; i < NUM_CLS; i++) begin
				head_ok_q[i] <= 1'b0;
			end
		end else begin
			if (cfg_we) begin
				chunk_q <= cfg_data;
			end
			if (state_q == S_FINISH && (!out_valid_q || out_ready)) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						blk_q  <= user_ext - ADDR_BITS'(HEADER_BYTES);
						user_q <= user_ext;
						res_q  <= '0;
						st_q   <= ST_IGNORED;
						rsz_q  <= (in_item.operation == OP_RESIZE) && (user_ext != '0);
						if (srch_start) begin
							state_q <= S_CLS_WAIT;
						end else if (in_item.operation == OP_FREE && user_ext != '0) begin
							state_q <= S_FREE_RD;
						end else begin
							state_q <= S_FINISH;
						end
					end
				end
				S_CLS_WAIT: begin
					if (srch_done) begin
						cls_q   <= srch_cls;
						state_q <= rsz_q ? S_RSZ_RD : S_ALLOC_DEC;
					end
				end
				S_ALLOC_DEC: begin
					if (cls_q > ch) begin
						st_q    <= ST_TOO_BIG;
						state_q <= S_FINISH;
					end else if (head_ok_q[cls_idx]) begin
						blk_q   <= head_addr_q[cls_idx];
						state_q <= S_POP_RD;
					end else if (exhausted) begin
						st_q    <= ST_NO_POOL;
						state_q <= S_FINISH;
					end else begin
						blk_q   <= cp_q[ADDR_BITS-1:0];
						cp_q    <= cp_q + csize[ADDR_BITS:0];
						res_q   <= cp_q[ADDR_BITS-1:0] + ADDR_BITS'(HEADER_BYTES);
						st_q    <= ST_OK;
						k_q     <= cls_q;
						hi_q    <= ch;
						state_q <= S_HALVES;
					end
				end
				S_POP_RD: state_q <= S_POP_WR;
				S_POP_WR: begin
					head_ok_q[cls_idx]   <= link_rdata[ADDR_BITS];
					head_addr_q[cls_idx] <= link_rdata[ADDR_BITS-1:0];
					res_q   <= blk_q + ADDR_BITS'(HEADER_BYTES);
					st_q    <= ST_OK;
					state_q <= S_FINISH;
				end
				S_FREE_RD: state_q <= S_FREE_DEC;
				S_FREE_DEC: begin
					if (!free_ign) begin
						head_ok_q[cap[HIDX_W-1:0]]   <= 1'b1;
						head_addr_q[cap[HIDX_W-1:0]] <= blk_q;
						st_q <= ST_OK;
					end
					state_q <= S_FINISH;
				end
				S_RSZ_RD: state_q <= S_RSZ_DEC;
				S_RSZ_DEC: begin
					if (cls_q <= cap) begin
						res_q   <= user_q;
						st_q    <= ST_OK;
						k_q     <= cls_q;
						hi_q    <= cap;
						state_q <= S_HALVES;
					end else begin
						st_q    <= ST_GROW;
						state_q <= S_FINISH;
					end
				end
				S_HALVES: begin
					if (halves_go) begin
						head_ok_q[k_q[HIDX_W-1:0]]   <= 1'b1;
						head_addr_q[k_q[HIDX_W-1:0]] <= half_a;
						k_q <= k_q + 1'b1;
					end else begin
						state_q <= S_FINISH;
					end
				end
				S_FINISH: begin
					if (!out_valid_q || out_ready) begin
						out_item_q.result_address <= USER_W'(res_q);
						out_item_q.status         <= st_q;
						state_q     <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	`ASSERT_AT(a_pool_bound, clk, arst_n, cp_q <= ((ADDR_BITS+1)'(1) << ADDR_BITS))
	`ASSERT_AT(a_halves_range, clk, arst_n, (state_q == S_HALVES) |-> (k_q <= hi_q))
	`ASSERT_AT(a_busy_after_req, clk, arst_n, accept |=> !in_ready)
	`ASSERT_NEVER_AT(a_search_idle, clk, arst_n, srch_done && state_q != S_CLS_WAIT)
endmodule

/* sim/tb_top.sv */
// Testbench for pow2_split_block_allocator: a scoreboard predicts each result
// from its own copy of the free lists, tags and chunk pointer.
// Depends on p2sa_pkg and the allocator RTL.
module tb_top;
	import p2sa_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int POOL_BITS = 20;
	localparam int HDR = 16;
	localparam int NCLS = POOL_BITS + 1;

	class alloc_scoreboard;
		bit head_ok[NCLS];
		logic [POOL_BITS-1:0] head_addr[NCLS];
		bit link_ok[65536];
		logic [POOL_BITS-1:0] link_addr[65536];
		logic [TAG_W-1:0] tag[65536];
		logic [POOL_BITS:0] chunk_ptr;
		logic [CFG_W-1:0] chunk_log2;
		out_item_t expected_q[$];
		logic [POOL_BITS-1:0] handed_out[$];
		int errors;

		function new();
			chunk_log2 = CHUNK_LOG2_RST;
			chunk_ptr = '0;
			errors = 0;
			foreach (head_ok[c]) head_ok[c] = 0;
		endfunction

		function int slot(logic [POOL_BITS-1:0] a);
			return int'(a >> 4);
		endfunction

		function int size_class(logic [REQ_W-1:0] req);
			longint sz;
			int c;
			sz = longint'(req) + HDR;
			c = 0;
			while ((64'd1 << c) < sz) c++;
			return c;
		endfunction

		function int eff_chunk();
			int c;
			c = chunk_log2;
			if (c < 5) c = 5;
			if (c > POOL_BITS) c = POOL_BITS;
			return c;
		endfunction

		function void push_block(logic [POOL_BITS-1:0] a, int cls);
			int i;
			i = slot(a);
			link_ok[i] = head_ok[cls];
			link_addr[i] = head_addr[cls];
			head_ok[cls] = 1;
			head_addr[cls] = a;
		endfunction

		function void push_halves(logic [POOL_BITS-1:0] b, int lo, int hi);
			logic [POOL_BITS-1:0] a;
			for (int k = lo; k < hi && k < POOL_BITS; k++) begin
				a = b + (20'd1 << k);
				tag[slot(a)] = TAG_W'(k);
				push_block(a, k);
			end
		endfunction

		function status_t allocate(logic [REQ_W-1:0] req, output logic [POOL_BITS-1:0] ua);
			int cls, ch, i;
			logic [POOL_BITS-1:0] blk;
			ua = '0;
			cls = size_class(req);
			ch = eff_chunk();
			if (cls > ch) return ST_TOO_BIG;
			if (head_ok[cls]) begin
				blk = head_addr[cls];
				i = slot(blk);
				tag[i] = TAG_W'(cls);
				head_ok[cls] = link_ok[i];
				head_addr[cls] = link_addr[i];
			end else begin
				if (longint'(chunk_ptr) + (64'd1 << ch) > (64'd1 << POOL_BITS))
					return ST_NO_POOL;
				blk = chunk_ptr[POOL_BITS-1:0];
				chunk_ptr = chunk_ptr + (21'd1 << ch);
				tag[slot(blk)] = TAG_W'(cls);
				push_halves(blk, cls, ch);
			end
			ua = blk + POOL_BITS'(HDR);
			return ST_OK;
		endfunction

		function void note_request(in_item_t it);
			out_item_t r;
			logic [POOL_BITS-1:0] ua, blk;
			status_t st;
			int cap, rq;
			ua = '0;
			st = ST_IGNORED;
			blk = it.user_address - POOL_BITS'(HDR);
			if (it.operation == OP_ALLOC || (it.operation == OP_RESIZE && it.user_address == 0)) begin
				st = allocate(it.request_bytes, ua);
				if (st == ST_OK) handed_out.push_back(ua);
			end else if (it.operation == OP_FREE) begin
				if (it.user_address != 0) begin
					cap = tag[slot(blk)];
					if (!(cap >= NCLS || (head_ok[cap] && head_addr[cap] == blk))) begin
						push_block(blk, cap);
						st = ST_OK;
					end
				end
			end else if (it.operation == OP_RESIZE) begin
				cap = tag[slot(blk)];
				rq = size_class(it.request_bytes);
				if (rq <= cap) begin
					tag[slot(blk)] = TAG_W'(rq);
					push_halves(blk, rq, cap);
					ua = it.user_address;
					st = ST_OK;
				end else st = ST_GROW;
			end
			r.result_address = ua;
			r.status = st;
			expected_q.push_back(r);
		endfunction

		function void check_result(out_item_t got);
			out_item_t e;
			if (expected_q.size() == 0) begin
				errors++;
				if (errors <= 10) $display("unexpected result addr=%h status=%0d",
					got.result_address, got.status);
				return;
			end
			e = expected_q.pop_front();
			if (got.result_address !== e.result_address || got.status !== e.status) begin
				errors++;
				if (errors <= 10) $display("mismatch: exp addr=%h status=%0d got addr=%h status=%0d",
					e.result_address, e.status, got.result_address, got.status);
			end
		endfunction
	endclass

	logic clk, arst_n;
	logic in_valid, in_ready, out_valid, out_ready, cfg_we;
	in_item_t in_item;
	out_item_t out_item;
	logic [CFG_W-1:0] cfg_data;
	alloc_scoreboard sb;
	bit tx_busy_mode, rx_busy_mode, long_hold;

	pow2_split_block_allocator dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready), .in_item(in_item),
		.out_valid(out_valid), .out_ready(out_ready), .out_item(out_item),
		.cfg_we(cfg_we), .cfg_data(cfg_data)
	);

	initial begin
		clk = 0;
		forever #10 clk = ~clk;
	end

	initial begin
		#50ms;
		$display("tb_top: FAIL");
		$finish;
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) sb.check_result(out_item);
	end

	// receiver: short random stalls, occasional long ones, one very long hold
	initial begin
		int stall;
		stall = 0;
		out_ready = 0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (long_hold) begin
				long_hold = 0;
				stall = 600;
			end
			if (stall > 0) begin
				out_ready <= 0;
				stall--;
			end else begin
				out_ready <= 1;
				if (rx_busy_mode && $urandom_range(0, 5) == 0)
					stall = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 80) : $urandom_range(1, 3);
			end
		end
	end

	task automatic send_request(in_item_t it);
		int gap;
		in_valid <= 1;
		in_item <= it;
		do @(posedge clk); while (!in_ready);
		sb.note_request(it);
		if (tx_busy_mode && $urandom_range(0, 3) == 0) begin
			gap = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 80) : $urandom_range(1, 3);
			in_valid <= 0;
			repeat (gap) @(posedge clk);
		end
	endtask

	task automatic drain();
		in_valid <= 0;
		while (sb.expected_q.size() != 0) @(posedge clk);
		repeat (40) @(posedge clk);
	endtask

	task automatic write_chunk_log2(logic [CFG_W-1:0] v);
		drain();
		cfg_we <= 1;
		cfg_data <= v;
		@(posedge clk);
		sb.chunk_log2 = v;
		cfg_we <= 0;
	endtask

	function automatic in_item_t make_req(op_t op, int req, logic [USER_W-1:0] ua);
		in_item_t it;
		it.operation = op;
		it.request_bytes = REQ_W'(req);
		it.user_address = ua;
		return it;
	endfunction

	function automatic logic [USER_W-1:0] pick_handed();
		if (sb.handed_out.size() == 0) return '0;
		return sb.handed_out[$urandom_range(0, sb.handed_out.size() - 1)];
	endfunction

	function automatic int rand_size();
		int r;
		r = $urandom_range(0, 99);
		if (r < 70) return $urandom_range(0, 240);
		if (r < 92) return $urandom_range(0, 8000);
		if (r < 97) return $urandom_range(0, 1 << 20);
		return $urandom_range(0, (1 << 21) - 1);
	endfunction

	function automatic in_item_t rand_req();
		in_item_t it;
		int r;
		r = $urandom_range(0, 99);
		it.request_bytes = REQ_W'(rand_size());
		it.user_address = USER_W'($urandom);
		if (r < 45) it.operation = OP_ALLOC;
		else if (r < 72) begin
			it.operation = OP_FREE;
			it.user_address = pick_handed();
		end else if (r < 92) begin
			it.operation = OP_RESIZE;
			it.user_address = pick_handed();
			if ($urandom_range(0, 1)) it.request_bytes = REQ_W'($urandom_range(0, 500));
		end else if (r < 96) begin
			it.operation = $urandom_range(0, 1) ? OP_FREE : OP_RESIZE;
			it.user_address = '0;
		end else it.operation = op_t'(2'd3);
		return it;
	endfunction

	initial begin
		logic [USER_W-1:0] a;
		int chunk_seq[7] = '{5, 20, 0, 31, 10, 12, 16};
		sb = new();
		arst_n = 0;
		in_valid = 0;
		in_item = '0;
		cfg_we = 0;
		cfg_data = '0;
		tx_busy_mode = 0;
		rx_busy_mode = 0;
		long_hold = 0;
		repeat (3) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// directed
		send_request(make_req(OP_ALLOC, 0, '1));
		send_request(make_req(OP_ALLOC, 1 << 20, '0));
		send_request(make_req(OP_ALLOC, (1 << 21) - 1, '0));
		send_request(make_req(OP_FREE, 0, '0));
		send_request(make_req(op_t'(2'd3), (1 << 21) - 1, '1));
		send_request(make_req(OP_RESIZE, 100, '0));
		send_request(make_req(OP_ALLOC, 4000, '0));
		a = sb.handed_out[sb.handed_out.size() - 1];
		send_request(make_req(OP_RESIZE, 9000, a));
		send_request(make_req(OP_RESIZE, 10, a));
		send_request(make_req(OP_FREE, 0, a));
		send_request(make_req(OP_FREE, 0, a));
		send_request(make_req(OP_ALLOC, 10, '0));
		send_request(make_req(OP_ALLOC, (1 << 16) - HDR, '0));
		send_request(make_req(OP_ALLOC, (1 << 16) - HDR + 1, '0));

		for (int p = 0; p < 7; p++) begin
			write_chunk_log2(CFG_W'(chunk_seq[p]));
			tx_busy_mode = (p % 3) != 1;
			rx_busy_mode = (p % 3) != 2;
			if (chunk_seq[p] == 0) send_request(make_req(OP_ALLOC, 16, '0));
			for (int n = 0; n < 125; n++) begin
				if (p == 4 && n == 20) long_hold = 1;
				send_request(rand_req());
			end
		end

		in_valid <= 0;
		while (sb.expected_q.size() != 0) @(posedge clk);
		repeat (50) @(posedge clk);
		if (sb.errors == 0) $display("tb_top: PASS");
		else $display("tb_top: FAIL");
		$finish;
	end
endmodule

/* sim.f */
+incdir+rtl/core
rtl/core/p2sa_pkg.sv
rtl/core/p2sa_store.sv
rtl/core/p2sa_class_search.sv
rtl/core/pow2_split_block_allocator.sv
sim/tb_top.sv
